### src/base64_stream_codec_top_defines.svh
//------------------------------------------------------------------------------
// base64 stream codec assertion macros
// shared assertion forms for the codec checker
//------------------------------------------------------------------------------
`ifndef BASE64_STREAM_CODEC_TOP_DEFINES_SVH
`define BASE64_STREAM_CODEC_TOP_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define B64SC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define B64SC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/b64sc_pkg.sv
//------------------------------------------------------------------------------
// b64sc_pkg
// types, constants and alphabet functions of the base64 stream codec
//------------------------------------------------------------------------------
`default_nettype none

package b64sc_pkg;

    localparam int unsigned CHAR_W = 8;

    // direction register codes
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // number of characters carried by one queued record
    localparam logic [1:0] NCHAR_NONE = 2'd0;
    localparam logic [1:0] NCHAR_ONE  = 2'd1;
    localparam logic [1:0] NCHAR_TWO  = 2'd2;

    // one queued transaction worth of results
    typedef struct packed {
        logic [1:0]        n_chars;
        logic [CHAR_W-1:0] char0;
        logic [CHAR_W-1:0] char1;
        logic              bad;
        logic              eom;
    } t_rec;

    // output sideband, char_valid in bit 0
    typedef struct packed {
        logic last_of_item;
        logic bad_symbol;
        logic char_valid;
    } t_user;

    localparam int unsigned USER_W = $bits(t_user);

    // 6-bit value to standard alphabet character
    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = 8'd65 + {2'b00, v};
        end else if (v < 6'd52) begin
            c = 8'd97 + {2'b00, v} - 8'd26;
        end else if (v < 6'd62) begin
            c = 8'd48 + {2'b00, v} - 8'd52;
        end else if (v == 6'd62) begin
            c = 8'd43;
        end else begin
            c = 8'd47;
        end
        return c;
    endfunction

    // alphabet character to {valid, 6-bit value}
    function automatic logic [6:0] dec_symbol(input logic [7:0] c);
        logic [6:0] r;
        if (c >= 8'd65 && c <= 8'd90) begin
            r = {1'b1, 6'(c - 8'd65)};
        end else if (c >= 8'd97 && c <= 8'd122) begin
            r = {1'b1, 6'(c - 8'd97 + 8'd26)};
        end else if (c >= 8'd48 && c <= 8'd57) begin
            r = {1'b1, 6'(c - 8'd48 + 8'd52)};
        end else if (c == 8'd43) begin
            r = {1'b1, 6'd62};
        end else if (c == 8'd47) begin
            r = {1'b1, 6'd63};
        end else begin
            r = 7'd0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### src/b64sc_front.sv
//------------------------------------------------------------------------------
// b64sc_front
// accepts input characters, runs the bit buffer and builds result records
//------------------------------------------------------------------------------
`default_nettype none

module b64sc_front
    import b64sc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic              i_cfg_wr_data,
    input  wire logic              i_valid,
    input  wire logic [CHAR_W-1:0] i_char,
    input  wire logic              i_eom,
    input  wire logic              i_room,
    output logic                   o_ready,
    output logic                   o_push,
    output t_rec                   o_rec
);

    logic       r_direction;
    logic [7:0] r_buf;
    logic [2:0] r_cnt;
    logic [7:0] n_buf;
    logic [2:0] n_cnt;

    logic       accept;
    logic [6:0] sym;
    logic [14:0] acc;
    logic [3:0] cnt_sum;
    logic [3:0] cnt_left;
    logic       bad;
    logic [14:0] keep_mask;

    assign o_ready = i_room;
    assign accept  = i_valid && i_room;
    assign sym     = dec_symbol(i_char);

    always_comb begin
        acc           = 15'd0;
        cnt_sum       = 4'd0;
        cnt_left      = 4'd0;
        bad           = 1'b0;
        o_rec.n_chars = NCHAR_NONE;
        o_rec.char0   = '0;
        o_rec.char1   = '0;
        if (r_direction == DIR_ENCODE) begin
            acc     = {r_buf[6:0], i_char};
            cnt_sum = {1'b0, r_cnt} + 4'd8;
            o_rec.char0 = enc_char(6'(acc >> (cnt_sum - 4'd6)));
            if (cnt_sum >= 4'd12) begin
                o_rec.n_chars = NCHAR_TWO;
                o_rec.char1   = enc_char(6'(acc >> (cnt_sum - 4'd12)));
                cnt_left      = cnt_sum - 4'd12;
            end else begin
                o_rec.n_chars = NCHAR_ONE;
                cnt_left      = cnt_sum - 4'd6;
            end
        end else begin
            if (sym[6]) begin
                acc     = {1'b0, r_buf, sym[5:0]};
                cnt_sum = {1'b0, r_cnt} + 4'd6;
            end else begin
                acc     = {7'd0, r_buf};
                cnt_sum = {1'b0, r_cnt};
                bad     = 1'b1;
            end
            if (cnt_sum >= 4'd8) begin
                o_rec.n_chars = NCHAR_ONE;
                o_rec.char0   = 8'(acc >> (cnt_sum - 4'd8));
                cnt_left      = cnt_sum - 4'd8;
            end else begin
                cnt_left      = cnt_sum;
            end
        end
        o_rec.bad = bad;
        o_rec.eom = i_eom;

        // leftover bits, dropped at end of message
        keep_mask = (15'd1 << cnt_left[2:0]) - 15'd1;
        if (i_eom) begin
            n_buf = 8'd0;
            n_cnt = 3'd0;
        end else begin
            n_buf = 8'(acc & keep_mask);
            n_cnt = cnt_left[2:0];
        end
    end

    assign o_push = accept && ((o_rec.n_chars != NCHAR_NONE) || bad || i_eom);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= DIR_ENCODE;
            r_buf       <= 8'd0;
            r_cnt       <= 3'd0;
        end else begin
            if (i_cfg_wr_en) begin
                r_direction <= i_cfg_wr_data;
            end
            if (accept) begin
                r_buf <= n_buf;
                r_cnt <= n_cnt;
            end
        end
    end

endmodule

`default_nettype wire

### src/b64sc_queue.sv
//------------------------------------------------------------------------------
// b64sc_queue
// short record queue between the front and the back
//------------------------------------------------------------------------------
`default_nettype none

module b64sc_queue
    import b64sc_pkg::*;
#(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_rec i_rec,
    input  wire logic i_pop,
    output logic      o_room,
    output logic      o_avail,
    output t_rec      o_rec
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_rec             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_room  = (r_count != CNT_W'(DEPTH));
    assign o_avail = (r_count != '0);
    assign o_rec   = r_mem[r_rd];
    assign do_push = i_push && o_room;
    assign do_pop  = i_pop && o_avail;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### src/b64sc_back.sv
//------------------------------------------------------------------------------
// b64sc_back
// unpacks queued records into result transactions on the output register
//------------------------------------------------------------------------------
`default_nettype none

module b64sc_back
    import b64sc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_avail,
    input  wire t_rec               i_rec,
    output logic                    o_pop,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [CHAR_W-1:0]       o_data,
    output logic [USER_W-1:0]       o_user,
    output logic                    o_last
);

    logic              r_valid;
    logic [CHAR_W-1:0] r_data;
    t_user             r_user;
    logic              r_last;
    logic              r_pend;
    logic [CHAR_W-1:0] r_pend_char;
    logic              r_pend_bad;
    logic              r_pend_eom;

    logic              n_valid;
    logic [CHAR_W-1:0] n_data;
    t_user             n_user;
    logic              n_last;
    logic              n_pend;

    logic              load;

    assign load = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        n_user  = r_user;
        n_last  = r_last;
        n_pend  = r_pend;
        o_pop   = 1'b0;
        if (load) begin
            if (r_pend) begin
                // second character of a two-character record
                n_valid             = 1'b1;
                n_data              = r_pend_char;
                n_user.char_valid   = 1'b1;
                n_user.bad_symbol   = r_pend_bad;
                n_user.last_of_item = 1'b1;
                n_last              = r_pend_eom;
                n_pend              = 1'b0;
            end else if (i_avail) begin
                o_pop             = 1'b1;
                n_valid           = 1'b1;
                n_user.bad_symbol = i_rec.bad;
                case (i_rec.n_chars)
                    NCHAR_NONE: begin
                        n_data              = '0;
                        n_user.char_valid   = 1'b0;
                        n_user.last_of_item = 1'b1;
                        n_last              = i_rec.eom;
                    end
                    NCHAR_ONE: begin
                        n_data              = i_rec.char0;
                        n_user.char_valid   = 1'b1;
                        n_user.last_of_item = 1'b1;
                        n_last              = i_rec.eom;
                    end
                    default: begin
                        n_data              = i_rec.char0;
                        n_user.char_valid   = 1'b1;
                        n_user.last_of_item = 1'b0;
                        n_last              = 1'b0;
                        n_pend              = 1'b1;
                    end
                endcase
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_user <= n_user;
        r_last <= n_last;
        if (o_pop) begin
            r_pend_char <= i_rec.char1;
            r_pend_bad  <= i_rec.bad;
            r_pend_eom  <= i_rec.eom;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_user  = r_user;
    assign o_last  = r_last;

endmodule

`default_nettype wire

### src/base64_stream_codec_top.sv
// Streaming base64 codec without padding. With the direction register at 0 it
// takes raw bytes and sends out one standard-alphabet character per 6 bits;
// at 1 it takes alphabet characters and sends out one byte per 8 bits. A
// character outside the alphabet (including '=') is flagged on tuser and adds
// no bits. tlast on the input ends a message: leftover bits are dropped and
// the buffer restarts empty. The input side accepts one transaction per
// clock as long as the record queue has room; an item yields zero, one or two
// result transactions, and the output register sends at most one per clock,
// so while the sink is ready the sustained rate is one item per cycle except
// where two-character encode items make the output side the limit. The first
// result of an item is written into the record queue and then loaded into the
// output register before it is on the output.
//------------------------------------------------------------------------------
// base64_stream_codec_top
// stream codec top level: front classifier, record queue, result serializer
//------------------------------------------------------------------------------
`default_nettype none

module base64_stream_codec_top
    import b64sc_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // direction register write, 0 encode, 1 decode
    input  wire logic              i_cfg_wr_en,
    input  wire logic              i_cfg_wr_data,
    // input stream
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [7:0]        s_axis_tdata,   // [7:0] in_char
    input  wire logic              s_axis_tlast,   // end_of_message
    // result stream
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [7:0]             m_axis_tdata,   // [7:0] out_char
    output logic [USER_W-1:0]      m_axis_tuser,   // [0] char_valid, [1] bad_symbol,
                                                   // [2] last_of_item
    output logic                   m_axis_tlast    // message_done
);

    // front to queue
    logic push;
    t_rec push_rec;
    logic room;

    // queue to back
    logic avail;
    logic pop;
    t_rec pop_rec;

    // front holds the direction register and the bit buffer; it decides per
    // transaction how many results follow and queues one record for them
    b64sc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (s_axis_tvalid),
        .i_char        (s_axis_tdata),
        .i_eom         (s_axis_tlast),
        .i_room        (room),
        .o_ready       (s_axis_tready),
        .o_push        (push),
        .o_rec         (push_rec)
    );

    // decouples input acceptance from output stalls
    b64sc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .i_pop   (pop),
        .o_room  (room),
        .o_avail (avail),
        .o_rec   (pop_rec)
    );

    // splits each record into one or two result transactions
    b64sc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (avail),
        .i_rec   (pop_rec),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_user  (m_axis_tuser),
        .o_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire

### src/b64sc_checker.sv
//------------------------------------------------------------------------------
// b64sc_checker
// port-level checks on the codec result stream
//------------------------------------------------------------------------------
`default_nettype none

`include "base64_stream_codec_top_defines.svh"

module b64sc_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic [2:0] m_axis_tuser,
    input wire logic       m_axis_tlast
);

    // stalled result holds its value
    `B64SC_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result changed")

    // flag-only result carries zero data and ends its item
    `B64SC_ASSERT_NOW(a_flag_only, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser[0], (m_axis_tdata == 8'd0) && m_axis_tuser[2], "flag-only result malformed")

    // message end only on the last result of an item
    `B64SC_ASSERT_NOW(a_done_last, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast, m_axis_tuser[2], "message_done without last_of_item")

    // a bad symbol never comes with a decoded byte
    `B64SC_ASSERT_NOW(a_bad_nochar, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[1], !m_axis_tuser[0], "bad symbol with char")

endmodule

bind base64_stream_codec_top b64sc_checker u_b64sc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

### tb/base64_stream_codec_top_test.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// base64_stream_codec_top_test
// sends byte and character messages through the codec in both directions,
// predicts every result transaction from a software copy of the bit buffer and
// checks it field by field under changing source idle and sink backpressure
//------------------------------------------------------------------------------
module base64_stream_codec_top_test;
    import b64sc_pkg::*;

    // cycles allowed after the last expected result for a record that yields
    // nothing to leave the front classifier and the record queue
    localparam int SETTLE_CYCLES = 12;

    // standard alphabet, first character in the top byte
    localparam logic [8*64-1:0] ALPHABET = {"ABCDEFGHIJKLMNOPQRSTUVWXYZ",
                                            "abcdefghijklmnopqrstuvwxyz",
                                            "0123456789+/"};

    // one result transaction as the sink should see it
    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       bad_symbol;
        logic       message_done;
        logic       last_of_item;
    } codec_result_t;

    // dut ports
    logic              i_clk;
    logic              i_rst_n        = 1'b0;
    logic              i_cfg_wr_en    = 1'b0;
    logic              i_cfg_wr_data  = 1'b0;
    logic              s_axis_tvalid  = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata   = 8'h00;   // [7:0] in_char
    logic              s_axis_tlast   = 1'b0;    // end_of_message
    logic              m_axis_tvalid;
    logic              m_axis_tready  = 1'b0;
    logic [7:0]        m_axis_tdata;             // [7:0] out_char
    logic [USER_W-1:0] m_axis_tuser;             // [0] char_valid, [1] bad_symbol,
                                                 // [2] last_of_item
    logic              m_axis_tlast;             // message_done

    // predicted codec state, follows every accepted input transaction
    logic              pred_direction = DIR_ENCODE;
    logic [7:0]        pend_bits      = 8'h00;
    int                pend_count     = 0;

    // results still owed by the dut, oldest first
    codec_result_t     expected_results_q[$];

    // traffic shaping, percent of cycles except for the forced stall length
    int                source_idle_pct   = 0;
    int                sink_stall_pct    = 0;
    int                sink_hold_cycles  = 0;

    // bookkeeping
    int                n_errors          = 0;
    int                n_items_sent      = 0;
    int                n_results_checked = 0;
    int                n_bad_flags       = 0;
    int                n_messages_done   = 0;
    int                n_dir_writes      = 0;

    base64_stream_codec_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 100 MHz clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // hard stop, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    //--------------------------------------------------------------------------
    // alphabet helpers
    //--------------------------------------------------------------------------

    // 6-bit value to its character
    function automatic logic [7:0] sextet_char(input int value);
        return ALPHABET[8*(63-value) +: 8];
    endfunction

    // character to its 6-bit value, -1 when it is not in the alphabet
    function automatic int sextet_of(input logic [7:0] c);
        for (int i = 0; i < 64; i++) begin
            if (sextet_char(i) == c) begin
                return i;
            end
        end
        return -1;
    endfunction

    //--------------------------------------------------------------------------
    // prediction: one accepted input transaction, zero to two results
    //--------------------------------------------------------------------------
    task automatic predict_codec_step(input logic [7:0] c, input logic eom);
        int            acc;
        int            cnt;
        int            unit;
        int            value;
        int            n;
        logic          bad;
        logic [7:0]    produced [2];
        codec_result_t r;

        acc = int'(pend_bits);
        cnt = pend_count;
        bad = 1'b0;
        n   = 0;

        if (pred_direction == DIR_ENCODE) begin
            acc  = (acc << 8) | int'(c);
            cnt += 8;
            unit = 6;
        end else begin
            // characters outside the alphabet, '=' too, add no bits
            value = sextet_of(c);
            if (value < 0) begin
                bad = 1'b1;
            end else begin
                acc  = (acc << 6) | value;
                cnt += 6;
            end
            unit = 8;
        end

        // at most 15 bits are ever held here, so at most two units come out
        while (cnt >= unit) begin
            value = (acc >> (cnt - unit)) & ((1 << unit) - 1);
            cnt  -= unit;
            produced[n] = (unit == 6) ? sextet_char(value) : value[7:0];
            n++;
        end
        acc &= (1 << cnt) - 1;

        // end of message drops whatever is left
        if (eom) begin
            acc = 0;
            cnt = 0;
        end
        pend_bits  = acc[7:0];
        pend_count = cnt;

        if (n == 0) begin
            // a bare flag result only when there is something to report
            if (bad || eom) begin
                r = '{8'h00, 1'b0, bad, eom, 1'b1};
                expected_results_q.push_back(r);
            end
        end else begin
            for (int k = 0; k < n; k++) begin
                r = '{produced[k], 1'b1, bad, (k == n - 1) && eom, k == n - 1};
                expected_results_q.push_back(r);
            end
        end
    endtask

    //--------------------------------------------------------------------------
    // sink side: tready pattern and result checking
    //--------------------------------------------------------------------------

    // tready changes on the falling edge; a hold forces a long stall
    always @(negedge i_clk) begin
        if (sink_hold_cycles > 0) begin
            m_axis_tready = 1'b0;
            sink_hold_cycles--;
        end else begin
            m_axis_tready = ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    function automatic void compare_field(input string field, input logic [7:0] want,
                                          input logic [7:0] got);
        if (got !== want) begin
            n_errors++;
            $display("%0t: %s mismatch, expected %02h, actual %02h",
                     $time, field, want, got);
        end
    endfunction

    // every accepted result transaction is matched against the oldest prediction
    always @(posedge i_clk) begin : result_check
        codec_result_t want;
        t_user         user;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            user = m_axis_tuser;
            if (expected_results_q.size() == 0) begin
                n_errors++;
                $display("%0t: result transaction with none expected, expected none, actual %02h/%03b/%0b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
            end else begin
                want = expected_results_q.pop_front();
                n_results_checked++;
                compare_field("out_char",     want.out_char,     m_axis_tdata);
                compare_field("char_valid",   8'(want.char_valid),   8'(user.char_valid));
                compare_field("bad_symbol",   8'(want.bad_symbol),   8'(user.bad_symbol));
                compare_field("message_done", 8'(want.message_done), 8'(m_axis_tlast));
                compare_field("last_of_item", 8'(want.last_of_item), 8'(user.last_of_item));
                if (user.bad_symbol === 1'b1) begin
                    n_bad_flags++;
                end
                if (m_axis_tlast === 1'b1) begin
                    n_messages_done++;
                end
            end
        end
    end

    //--------------------------------------------------------------------------
    // source side
    //--------------------------------------------------------------------------

    // offer one input transaction, with random idle cycles in front of it
    task automatic send_item(input logic [7:0] c, input logic eom);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < source_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = c;
        s_axis_tlast  = eom;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_codec_step(c, eom);
        n_items_sent++;
    endtask

    // stop offering and wait until every predicted result has been seen
    task automatic wait_until_drained();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        s_axis_tlast  = 1'b0;
        while (expected_results_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // direction is only changed with the codec idle; pending bits carry over
    task automatic write_direction(input logic dir);
        wait_until_drained();
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = dir;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
        pred_direction = dir;
        n_dir_writes++;
    endtask

    // random message; decode mostly uses alphabet characters, the rest noise
    task automatic send_random_message(input int len, input logic close);
        logic [7:0] c;
        logic       eom;
        for (int i = 0; i < len; i++) begin
            if (pred_direction == DIR_DECODE && $urandom_range(0, 99) < 85) begin
                c = sextet_char($urandom_range(0, 63));
            end else begin
                c = 8'($urandom_range(0, 255));
            end
            // rare early end breaks a message in two
            eom = (close && i == len - 1) || ($urandom_range(0, 99) == 0);
            send_item(c, eom);
        end
    endtask

    //--------------------------------------------------------------------------
    // tests
    //--------------------------------------------------------------------------

    // encode straight out of reset, direction left at its reset value
    task automatic test_encode_directed();
        send_item("M", 1'b0);
        send_item("a", 1'b0);
        send_item("n", 1'b1);       // TWFu
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h01, 1'b1);     // a full 24-bit group at the extremes
        send_item(8'h80, 1'b1);     // one byte, the two leftover bits dropped
    endtask

    task automatic test_decode_directed();
        write_direction(DIR_DECODE);
        send_item("T", 1'b0);
        send_item("W", 1'b0);
        send_item("F", 1'b0);
        send_item("u", 1'b1);       // Man
        send_item("/", 1'b0);
        send_item("/", 1'b0);
        send_item("/", 1'b0);
        send_item("/", 1'b0);       // three all-ones bytes
        send_item("A", 1'b1);       // end of message with nothing produced
        send_item("Z", 1'b0);
        send_item("=", 1'b0);       // padding is outside the alphabet
        send_item("a", 1'b0);
        send_item("9", 1'b0);
        send_item("+", 1'b1);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item("@", 1'b0);
        send_item("{", 1'b0);
        send_item(":", 1'b1);       // bad symbol that also ends the message
    endtask

    // leftover bits survive a direction change and feed the new rule
    task automatic test_direction_switch();
        write_direction(DIR_ENCODE);
        send_item(8'hC3, 1'b0);     // one character, two bits left
        write_direction(DIR_DECODE);
        send_item("g", 1'b0);       // two plus six bits make a byte
        send_item("Q", 1'b0);       // six bits pending, no result
        write_direction(DIR_ENCODE);
        send_item(8'h5A, 1'b1);     // fourteen bits, two characters
    endtask

    // long sink stall while the source keeps offering, then a full drain
    task automatic test_sink_backpressure();
        write_direction(DIR_ENCODE);
        source_idle_pct = 0;
        sink_stall_pct  = 0;
        @(posedge i_clk);
        sink_hold_cycles = 400;
        send_random_message(40, 1'b1);
        wait_until_drained();
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                     input int n_items);
        int target;
        int len;
        source_idle_pct = idle_pct;
        sink_stall_pct  = stall_pct;
        target = n_items_sent + n_items;
        while (n_items_sent < target) begin
            if ($urandom_range(0, 3) == 0) begin
                write_direction(~pred_direction);
            end
            // mostly short messages, now and then a long one
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                              : $urandom_range(1, 8);
            // a few are left open so the next one inherits their bits
            send_random_message(len, $urandom_range(0, 19) != 0);
        end
    endtask

    //--------------------------------------------------------------------------
    // sequence
    //--------------------------------------------------------------------------
    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_encode_directed();
        test_decode_directed();
        test_direction_switch();
        test_sink_backpressure();
        test_random_phase(0, 0, 120);       // no idling
        test_random_phase(60, 0, 120);      // sparse source
        test_random_phase(0, 60, 120);      // stalling sink
        test_random_phase(7, 7, 120);       // light idling on both sides
        wait_until_drained();

        $display("covered %0d input and %0d result transactions, %0d flagged symbols,",
                 n_items_sent, n_results_checked, n_bad_flags);
        $display("%0d completed messages and %0d direction writes under four traffic mixes",
                 n_messages_done, n_dir_writes);
        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### files.f
+incdir+src
src/b64sc_pkg.sv
src/b64sc_front.sv
src/b64sc_queue.sv
src/b64sc_back.sv
src/base64_stream_codec_top.sv
src/b64sc_checker.sv
tb/base64_stream_codec_top_test.sv
